@@ sv/ucce_pkg.sv @@
// Shared types, codes and helpers for the UTF-8 console cursor engine.
`timescale 1ns / 1ps

package ucce_pkg;

  // Screen bounds of the text array
  localparam int MAX_COLUMNS = 128;
  localparam int MAX_ROWS    = 48;

  // Field widths
  localparam int BYTE_W  = 8;
  localparam int COL_W   = 7;
  localparam int ROW_W   = 6;
  localparam int CP_W    = 16;
  localparam int PART_W  = 21;
  localparam int KIND_W  = 2;
  localparam int ODATA_W = 48;

  // Register reset values
  localparam logic [COL_W-1:0] LAST_COLUMN_RST = 7'd79;
  localparam logic [ROW_W-1:0] LAST_ROW_RST    = 6'd24;

  // Control bytes and substitute glyphs
  localparam logic [BYTE_W-1:0] BYTE_LF = 8'h0A;
  localparam logic [BYTE_W-1:0] BYTE_BS = 8'h08;
  localparam logic [CP_W-1:0]   CP_SPACE    = 16'h0020;
  localparam logic [CP_W-1:0]   CP_QUESTION = 16'h003F;

  // Configuration register indexes
  typedef enum logic {
    CFG_LAST_COLUMN = 1'b0,
    CFG_LAST_ROW    = 1'b1
  } cfg_index_t;

  // Event codes carried on tuser
  typedef enum logic [KIND_W-1:0] {
    EV_ABSORB    = 2'd0,
    EV_GLYPH     = 2'd1,
    EV_LINE_FEED = 2'd2,
    EV_BACKSPACE = 2'd3
  } event_kind_t;

  // One result item
  typedef struct packed {
    logic [ROW_W-1:0] new_cursor_row;
    logic [COL_W-1:0] new_cursor_column;
    logic             bad_byte;
    logic             scroll_up;
    logic [CP_W-1:0]  code_point;
    logic [COL_W-1:0] cell_column;
    logic [ROW_W-1:0] cell_row;
  } result_t;

  // Column register limited to the array width
  function automatic logic [COL_W-1:0] eff_col(input logic [COL_W-1:0] c);
    if (int'(c) > MAX_COLUMNS - 1) begin
      return COL_W'(MAX_COLUMNS - 1);
    end
    return c;
  endfunction

  // Row register limited to the array height
  function automatic logic [ROW_W-1:0] eff_row(input logic [ROW_W-1:0] r);
    if (int'(r) > MAX_ROWS - 1) begin
      return ROW_W'(MAX_ROWS - 1);
    end
    return r;
  endfunction

endpackage

@@ sv/utf8_console_cursor_engine.sv @@
// Top level: UTF-8 decoder and text cursor tracker, one byte per transfer.
`timescale 1ns / 1ps
// Each result is registered in the output register, or in the skid register if
// that one is stalled. Throughput: one byte per cycle while in_tready is high;
// decode and cursor update are one shallow combinational step from the state
// registers into the output register. The skid register keeps in_tready high
// for one more byte while a result waits. Reset (rst_n low, synchronous) clears
// the cursor, the decoder and both output stages; last_column=79, last_row=24.

module utf8_console_cursor_engine (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration write port
  input  logic                          cfg_wr_en,
  input  logic                          cfg_index,
  input  logic [ucce_pkg::COL_W-1:0]    cfg_wdata,
  // input stream
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [ucce_pkg::BYTE_W-1:0]   in_tdata,   // [7:0] data_byte
  // result stream
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // [5:0] cell_row, [12:6] cell_column, [28:13] code_point, [29] scroll_up,
  // [30] bad_byte, [37:31] new_cursor_column, [43:38] new_cursor_row, [47:44] 0
  output logic [ucce_pkg::ODATA_W-1:0]  out_tdata,
  output logic [ucce_pkg::KIND_W-1:0]   out_tuser   // [1:0] event_kind
);

  localparam int RES_W = $bits(ucce_pkg::result_t);

  // Configuration and decoder state
  logic [ucce_pkg::COL_W-1:0]  last_col_r;
  logic [ucce_pkg::ROW_W-1:0]  last_row_r;
  logic [1:0]                  remain_r, remain_nxt;
  logic [ucce_pkg::PART_W-1:0] part_r, part_nxt;
  logic [ucce_pkg::COL_W-1:0]  col_r, col_nxt;
  logic [ucce_pkg::ROW_W-1:0]  row_r, row_nxt;

  // Output register and skid stage
  logic                   out_vld_r, skid_vld_r;
  ucce_pkg::result_t      out_res_r, skid_res_r, res_nxt;
  ucce_pkg::event_kind_t  out_kind_r, skid_kind_r, kind_nxt;

  logic in_xfer, out_xfer;

  // Decode scratch
  logic [ucce_pkg::BYTE_W-1:0] b;
  logic [ucce_pkg::COL_W-1:0]  ecol, ecol_cfg;
  logic [ucce_pkg::ROW_W-1:0]  erow, erow_cfg;
  logic [ucce_pkg::PART_W-1:0] cp_full;
  logic [ucce_pkg::COL_W:0]    col_p1;
  logic                        render;

  assign in_tready = !skid_vld_r;
  assign in_xfer   = in_tvalid && in_tready;
  assign out_xfer  = out_tvalid && out_tready;

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {(ucce_pkg::ODATA_W - RES_W)'(0), out_res_r};
  assign out_tuser  = out_kind_r;

  assign b    = in_tdata;
  assign ecol = ucce_pkg::eff_col(last_col_r);
  assign erow = ucce_pkg::eff_row(last_row_r);
  assign ecol_cfg = ucce_pkg::eff_col(cfg_wdata);
  assign erow_cfg = ucce_pkg::eff_row(cfg_wdata[ucce_pkg::ROW_W-1:0]);

  // Decode one byte and advance the cursor
  always_comb begin
    remain_nxt = remain_r;
    part_nxt   = part_r;
    col_nxt    = col_r;
    row_nxt    = row_r;
    res_nxt    = '0;
    kind_nxt   = ucce_pkg::EV_ABSORB;
    render     = 1'b0;
    cp_full    = '0;
    col_p1     = '0;

    if (b == ucce_pkg::BYTE_LF) begin
      kind_nxt = ucce_pkg::EV_LINE_FEED;
      col_nxt  = '0;
      if (row_r >= erow) begin
        row_nxt           = erow;
        res_nxt.scroll_up = 1'b1;
      end else begin
        row_nxt = row_r + 1'b1;
      end
    end else if (b == ucce_pkg::BYTE_BS) begin
      // blank the cell left of the cursor, or column 0 in place
      if (col_r != '0) begin
        col_nxt = col_r - 1'b1;
      end
      kind_nxt            = ucce_pkg::EV_BACKSPACE;
      res_nxt.cell_row    = row_r;
      res_nxt.cell_column = col_nxt;
      res_nxt.code_point  = ucce_pkg::CP_SPACE;
    end else if (remain_r == 2'd0) begin
      // lead byte
      if (b[7] == 1'b0) begin
        cp_full = {13'd0, b};
        render  = 1'b1;
      end else if (b[7:5] == 3'b110) begin
        remain_nxt = 2'd1;
        part_nxt   = {16'd0, b[4:0]};
      end else if (b[7:4] == 4'b1110) begin
        remain_nxt = 2'd2;
        part_nxt   = {17'd0, b[3:0]};
      end else if (b[7:3] == 5'b11110) begin
        remain_nxt = 2'd3;
        part_nxt   = {18'd0, b[2:0]};
      end else begin
        res_nxt.bad_byte = 1'b1;
      end
    end else if (b[7:6] == 2'b10) begin
      // continuation byte
      part_nxt   = {part_r[ucce_pkg::PART_W-7:0], b[5:0]};
      remain_nxt = remain_r - 1'b1;
      if (remain_nxt == 2'd0) begin
        cp_full = part_nxt;
        render  = 1'b1;
      end
    end else begin
      // sequence broken: back to idle, byte dropped
      remain_nxt       = 2'd0;
      res_nxt.bad_byte = 1'b1;
    end

    // glyph write and cursor advance with wrap and scroll
    if (render) begin
      kind_nxt            = ucce_pkg::EV_GLYPH;
      res_nxt.cell_row    = row_r;
      res_nxt.cell_column = col_r;
      res_nxt.code_point  = (cp_full > 21'h00FFFF) ? ucce_pkg::CP_QUESTION
                                                   : cp_full[ucce_pkg::CP_W-1:0];
      col_p1 = {1'b0, col_r} + 1'b1;
      if (col_p1 > {1'b0, ecol}) begin
        col_nxt = '0;
        if (row_r >= erow) begin
          row_nxt           = erow;
          res_nxt.scroll_up = 1'b1;
        end else begin
          row_nxt = row_r + 1'b1;
        end
      end else begin
        col_nxt = col_p1[ucce_pkg::COL_W-1:0];
      end
    end

    res_nxt.new_cursor_column = col_nxt;
    res_nxt.new_cursor_row    = row_nxt;
  end

  // Configuration, decoder and cursor registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_col_r <= ucce_pkg::LAST_COLUMN_RST;
      last_row_r <= ucce_pkg::LAST_ROW_RST;
      remain_r   <= '0;
      part_r     <= '0;
      col_r      <= '0;
      row_r      <= '0;
    end else if (cfg_wr_en) begin
      // new bound pulls the cursor inside it
      case (ucce_pkg::cfg_index_t'(cfg_index))
        ucce_pkg::CFG_LAST_COLUMN: begin
          last_col_r <= cfg_wdata;
          if (col_r > ecol_cfg) col_r <= ecol_cfg;
        end
        ucce_pkg::CFG_LAST_ROW: begin
          last_row_r <= cfg_wdata[ucce_pkg::ROW_W-1:0];
          if (row_r > erow_cfg) row_r <= erow_cfg;
        end
        default: begin
          last_col_r <= last_col_r;
        end
      endcase
    end else if (in_xfer) begin
      remain_r <= remain_nxt;
      part_r   <= part_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
    end
  end

  // Output register with skid stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (skid_vld_r) begin
      if (out_xfer) begin
        out_res_r  <= skid_res_r;
        out_kind_r <= skid_kind_r;
        skid_vld_r <= 1'b0;
      end
    end else if (in_xfer) begin
      if (!out_vld_r || out_xfer) begin
        out_res_r  <= res_nxt;
        out_kind_r <= kind_nxt;
        out_vld_r  <= 1'b1;
      end else begin
        skid_res_r  <= res_nxt;
        skid_kind_r <= kind_nxt;
        skid_vld_r  <= 1'b1;
      end
    end else if (out_xfer) begin
      out_vld_r <= 1'b0;
    end
  end

endmodule

@@ sv/ucce_checker.sv @@
// Port-level checks for the UTF-8 console cursor engine, bound to the top level.
`timescale 1ns / 1ps

module ucce_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [ucce_pkg::ODATA_W-1:0]  out_tdata,
  input logic [ucce_pkg::KIND_W-1:0]   out_tuser
);

  // A stalled result holds its payload
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // Reset empties the output side
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // A dropped byte writes no cell
  a_bad_absorbs: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[30] |-> out_tuser == ucce_pkg::EV_ABSORB)
    else $error("bad byte with a cell write");

  // Backspace blanks with a space
  a_bs_space: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ucce_pkg::EV_BACKSPACE |->
      out_tdata[28:13] == ucce_pkg::CP_SPACE && !out_tdata[29])
    else $error("backspace result malformed");

  // Scrolling leaves the cursor at column 0
  a_scroll_col0: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[29] |-> out_tdata[37:31] == '0)
    else $error("scroll without return to column 0");

endmodule

bind utf8_console_cursor_engine ucce_checker u_ucce_checker (.*);

@@ tb/utf8_console_cursor_engine_test.sv @@
// Self-checking bench for the UTF-8 console cursor engine: byte stream in, cell events out.
`timescale 1ns / 1ps

module utf8_console_cursor_engine_test;
  import ucce_pkg::*;

  // Expected event for one byte
  typedef struct {
    event_kind_t kind;
    result_t     fields;
  } cell_event_t;

  // Screen and decoder tracker; queues the event each accepted byte should cause
  class cursor_scoreboard;
    int               col_reg;
    int               row_reg;
    int               seq_left;
    logic [PART_W-1:0] seq_code;
    int               cur_col;
    int               cur_row;
    int               errors;
    cell_event_t      events_due[$];

    function new();
      col_reg  = int'(LAST_COLUMN_RST);
      row_reg  = int'(LAST_ROW_RST);
      seq_left = 0;
      seq_code = '0;
      cur_col  = 0;
      cur_row  = 0;
      errors   = 0;
    endfunction

    function int col_limit();
      return (col_reg > MAX_COLUMNS - 1) ? MAX_COLUMNS - 1 : col_reg;
    endfunction

    function int row_limit();
      return (row_reg > MAX_ROWS - 1) ? MAX_ROWS - 1 : row_reg;
    endfunction

    function void saturate_cursor();
      if (cur_col > col_limit()) cur_col = col_limit();
      if (cur_row > row_limit()) cur_row = row_limit();
    endfunction

    // New line; returns 1 when the screen scrolls
    function bit line_down();
      cur_col = 0;
      if (cur_row >= row_limit()) begin
        cur_row = row_limit();
        return 1'b1;
      end
      cur_row++;
      return 1'b0;
    endfunction

    function void set_register(cfg_index_t idx, logic [COL_W-1:0] value);
      if (idx == CFG_LAST_COLUMN) col_reg = int'(value);
      else col_reg = col_reg;
      if (idx == CFG_LAST_ROW) row_reg = int'(value[ROW_W-1:0]);
      saturate_cursor();
    endfunction

    function int pending();
      return events_due.size();
    endfunction

    // Work out the event for one accepted byte
    function void note_byte(logic [BYTE_W-1:0] b);
      cell_event_t       ev;
      logic [PART_W-1:0] glyph;
      bit                draw;
      ev.kind   = EV_ABSORB;
      ev.fields = '0;
      glyph     = '0;
      draw      = 1'b0;
      saturate_cursor();
      if (b == BYTE_LF) begin
        ev.kind = EV_LINE_FEED;
        ev.fields.scroll_up = line_down();
      end else if (b == BYTE_BS) begin
        if (cur_col > 0) cur_col--;
        ev.kind = EV_BACKSPACE;
        ev.fields.cell_row    = ROW_W'(cur_row);
        ev.fields.cell_column = COL_W'(cur_col);
        ev.fields.code_point  = CP_SPACE;
      end else if (seq_left == 0) begin
        // idle decoder: plain byte or a lead byte
        if (b[7] == 1'b0) begin
          glyph = PART_W'(b);
          draw  = 1'b1;
        end else if (b[7:5] == 3'b110) begin
          seq_left = 1;
          seq_code = PART_W'(b[4:0]);
        end else if (b[7:4] == 4'b1110) begin
          seq_left = 2;
          seq_code = PART_W'(b[3:0]);
        end else if (b[7:3] == 5'b11110) begin
          seq_left = 3;
          seq_code = PART_W'(b[2:0]);
        end else begin
          ev.fields.bad_byte = 1'b1;
        end
      end else if (b[7:6] == 2'b10) begin
        seq_code = {seq_code[PART_W-7:0], b[5:0]};
        seq_left--;
        if (seq_left == 0) begin
          glyph = seq_code;
          draw  = 1'b1;
        end
      end else begin
        // broken sequence: decoder back to idle, byte dropped
        seq_left = 0;
        ev.fields.bad_byte = 1'b1;
      end
      if (draw) begin
        ev.kind = EV_GLYPH;
        ev.fields.code_point  = (glyph > 21'h00FFFF) ? CP_QUESTION : glyph[CP_W-1:0];
        ev.fields.cell_row    = ROW_W'(cur_row);
        ev.fields.cell_column = COL_W'(cur_col);
        cur_col++;
        if (cur_col > col_limit()) ev.fields.scroll_up = line_down();
      end
      ev.fields.new_cursor_column = COL_W'(cur_col);
      ev.fields.new_cursor_row    = ROW_W'(cur_row);
      events_due.push_back(ev);
    endfunction

    function void field_check(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
        errors++;
      end
    endfunction

    // Compare one result transfer with the oldest expectation
    function void check_result(logic [KIND_W-1:0] kind, logic [ODATA_W-1:0] data);
      cell_event_t ev;
      result_t     got;
      if (events_due.size() == 0) begin
        $display("%0t: unexpected result, kind %0d data 0x%0h", $time, kind, data);
        errors++;
        return;
      end
      ev  = events_due.pop_front();
      got = data[$bits(result_t)-1:0];
      field_check("event_kind", ev.kind, kind);
      field_check("cell_row", ev.fields.cell_row, got.cell_row);
      field_check("cell_column", ev.fields.cell_column, got.cell_column);
      field_check("code_point", ev.fields.code_point, got.code_point);
      field_check("scroll_up", ev.fields.scroll_up, got.scroll_up);
      field_check("bad_byte", ev.fields.bad_byte, got.bad_byte);
      field_check("new_cursor_column", ev.fields.new_cursor_column, got.new_cursor_column);
      field_check("new_cursor_row", ev.fields.new_cursor_row, got.new_cursor_row);
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_wr_en;
  cfg_index_t           cfg_index;
  logic [COL_W-1:0]     cfg_wdata;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [BYTE_W-1:0]    in_tdata;
  logic                 out_tvalid;
  logic                 out_tready;
  logic [ODATA_W-1:0]   out_tdata;
  logic [KIND_W-1:0]    out_tuser;

  cursor_scoreboard     screen_sb;
  int                   bytes_sent;
  int                   tx_idle_pct;
  int                   rx_idle_pct;
  int                   stall_left;
  bit                   stall_done;

  utf8_console_cursor_engine uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // 10 ns clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Watchdog
  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  // Result side: random back-pressure plus one long hold-off
  initial begin
    out_tready = 1'b0;
    stall_left = 0;
    stall_done = 1'b0;
    forever begin
      @(negedge clk);
      if (!stall_done && bytes_sent >= 600) begin
        stall_left = 150;
        stall_done = 1'b1;
      end
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Result transfers
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) screen_sb.check_result(out_tuser, out_tdata);
  end

  // One byte transfer; called and returns at a falling edge
  task automatic send_byte(logic [BYTE_W-1:0] b);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    screen_sb.note_byte(b);
    bytes_sent++;
    @(negedge clk);
  endtask

  // Write both registers back to back while the block is idle
  task automatic program_screen(logic [COL_W-1:0] col, logic [ROW_W-1:0] row);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_LAST_COLUMN;
    cfg_wdata <= col;
    @(posedge clk);
    screen_sb.set_register(CFG_LAST_COLUMN, col);
    @(negedge clk);
    cfg_index <= CFG_LAST_ROW;
    cfg_wdata <= COL_W'(row);
    @(posedge clk);
    screen_sb.set_register(CFG_LAST_ROW, COL_W'(row));
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic drain();
    while (screen_sb.pending() > 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  // Mostly well-formed UTF-8 with random content, plus control bytes and noise
  task automatic send_random_unit();
    int                pick;
    int                len;
    logic [BYTE_W-1:0] lead;
    pick = $urandom_range(99);
    if (pick < 55) begin
      len = $urandom_range(1, 4);
      case (len)
        1:       lead = {1'b0, 7'($urandom)};
        2:       lead = {3'b110, 5'($urandom)};
        3:       lead = {4'b1110, 4'($urandom)};
        default: lead = {5'b11110, 3'($urandom)};
      endcase
      send_byte(lead);
      for (int i = 1; i < len; i++) begin
        pick = $urandom_range(99);
        if (pick < 4) begin
          // control byte in the middle of a sequence
          send_byte(($urandom_range(1) == 1) ? BYTE_LF : BYTE_BS);
        end else if (pick < 8) begin
          // break the sequence with a non-continuation byte
          send_byte({($urandom_range(1) == 1) ? 2'b11 : 2'b00, 6'($urandom)});
          return;
        end
        send_byte({2'b10, 6'($urandom)});
      end
    end else if (pick < 70) begin
      send_byte(BYTE_LF);
    end else if (pick < 80) begin
      send_byte(BYTE_BS);
    end else begin
      send_byte(8'($urandom));
    end
  endtask

  initial begin
    logic [BYTE_W-1:0] opening [];
    logic [COL_W-1:0]  col_set [9];
    logic [ROW_W-1:0]  row_set [9];
    int                phase_start;

    screen_sb   = new();
    bytes_sent  = 0;
    tx_idle_pct = 7;
    rx_idle_pct = 68;
    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_index   = CFG_LAST_COLUMN;
    cfg_wdata   = '0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed opening at the reset settings: extremes, every encoding length,
    // control bytes inside sequences, stray and broken bytes, overlong, surrogate
    opening = '{8'h00, 8'h7F, 8'h0A, 8'h08, 8'hC3, 8'hA9, 8'hE2, 8'h82, 8'hAC,
                8'hF0, 8'h9F, 8'h98, 8'h80, 8'hE2, 8'h0A, 8'h82, 8'hAC,
                8'hC3, 8'h08, 8'hA9, 8'h80, 8'hFF, 8'hC3, 8'h41, 8'hC0, 8'h80,
                8'hED, 8'hA0, 8'h80, 8'h01};
    foreach (opening[i]) send_byte(opening[i]);
    in_tvalid <= 1'b0;
    drain();

    // Screen settings: smallest, largest, row above bound, shrink below cursor
    col_set = '{7'd0, 7'd127, 7'd5, 7'd127, 7'd0, 7'd9, 7'd0, 7'd0, 7'd0};
    row_set = '{6'd0, 6'd47, 6'd63, 6'd0, 6'd47, 6'd3, 6'd0, 6'd0, 6'd0};
    for (int p = 6; p < 9; p++) begin
      col_set[p] = COL_W'($urandom_range(127));
      row_set[p] = ROW_W'($urandom_range(63));
    end

    for (int p = 0; p < 9; p++) begin
      if (p < 3) begin
        tx_idle_pct = 7;
        rx_idle_pct = 68;
      end else if (p < 6) begin
        tx_idle_pct = 68;
        rx_idle_pct = 7;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      program_screen(col_set[p], row_set[p]);
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < 200) send_random_unit();
      in_tvalid <= 1'b0;
      drain();
    end

    repeat (5) @(posedge clk);
    screen_sb.errors += screen_sb.pending();
    if (screen_sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/ucce_pkg.sv
sv/utf8_console_cursor_engine.sv
sv/ucce_checker.sv
tb/utf8_console_cursor_engine_test.sv
